// ===== rtl/weighted_random_entry_selector_top_defines.svh =====
// Assertion macros shared by the checker of the weighted random entry selector.
`ifndef WEIGHTED_RANDOM_ENTRY_SELECTOR_TOP_DEFINES_SVH
`define WEIGHTED_RANDOM_ENTRY_SELECTOR_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define WRES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define WRES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wres_pkg.sv =====
// Shared constants, types and helpers of the weighted random entry selector.
package wres_pkg;

    localparam int ENTRIES_PER_TABLE = 16;
    localparam int TABLE_COUNT       = 2;
    localparam int WEIGHT_BITS       = 16;

    localparam int SLOTS      = ENTRIES_PER_TABLE * TABLE_COUNT;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_BITS   = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;
    localparam int CNT_BITS   = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int TOTAL_BITS = WEIGHT_BITS + $clog2(ENTRIES_PER_TABLE + 1);
    localparam int FRAC_BITS  = 16;
    localparam int SPEED_BITS = 16;
    localparam int PROD_BITS  = FRAC_BITS + TOTAL_BITS;

    // Fixed widths of the port fields.
    localparam int IN_IDX_BITS    = 4;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int OUT_IDX_BITS   = 4;
    localparam int IN_DATA_BITS   = 72;
    localparam int IN_USER_BITS   = 2;
    localparam int OUT_DATA_BITS  = 8;

    typedef struct packed {
        logic                   en;
        logic [SLOT_BITS-1:0]   addr;
        logic [WEIGHT_BITS-1:0] weight;
        logic [SPEED_BITS-1:0]  min_speed;
        logic                   present;
    } wres_wr_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
    } wres_rd_t;

    typedef struct packed {
        logic                   valid;
        logic                   eligible;
        logic [WEIGHT_BITS-1:0] weight;
    } wres_rsp_t;

    function automatic logic [SLOT_BITS-1:0] slot_addr(input logic tbl,
                                                       input logic [IDX_BITS-1:0] idx);
        return SLOT_BITS'(int'(tbl) * ENTRIES_PER_TABLE + int'(idx));
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] sat_weight(input logic [IN_WEIGHT_BITS-1:0] w);
        logic [32:0] wide;
        logic [32:0] maxv;
        wide = 33'(w);
        maxv = (33'(1) << WEIGHT_BITS) - 33'(1);
        if (wide > maxv)
            return '1;
        return WEIGHT_BITS'(wide);
    endfunction

endpackage

// ===== rtl/wres_store.sv =====
// Entry store: weight and minimum speed memory, present flags, eligibility test.
module wres_store
    import wres_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wres_wr_t              wr,
    input  wres_rd_t              rd,
    input  logic [SPEED_BITS-1:0] speed,
    output wres_rsp_t             rsp
);

    typedef struct packed {
        logic [SPEED_BITS-1:0]  min_speed;
        logic [WEIGHT_BITS-1:0] weight;
    } entry_t;

    entry_t             mem [SLOTS];
    entry_t             rdata_reg;
    logic [SLOTS-1:0]   present_reg;
    logic               rd_present_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= '{min_speed: wr.min_speed, weight: wr.weight};
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                present_reg[wr.addr] <= wr.present;
            end
            rd_valid_reg <= rd.en;
            if (rd.en)
            begin
                rd_present_reg <= present_reg[rd.addr];
            end
        end
    end

    assign rsp.valid    = rd_valid_reg;
    assign rsp.eligible = rd_present_reg && (speed >= rdata_reg.min_speed);
    assign rsp.weight   = rdata_reg.weight;

endmodule

// ===== rtl/weighted_random_entry_selector_top.sv =====
// Top level of the weighted random entry selector: stream ports and selection sequencer.
// A write word produces no result and keeps the input ready for the next word.
// A select word gives its result after one memory read per entry for the total, then, if
// it is nonzero, the scaling multiply and one read per entry up to the chosen one (scan).
// One select is in work at a time; the result register frees the input while it waits.
// rst_n clears the present flags, the sequencer and the result register asynchronously.
module weighted_random_entry_selector_top
    import wres_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // entry_index, entry_weight, entry_min_speed, entry_present, speed, random_fraction
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // action, table_id
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // selected_index
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // found
    output logic                     m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic                    tbl_reg;
    logic [SPEED_BITS-1:0]   speed_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [TOTAL_BITS-1:0]   acc_reg;
    logic [TOTAL_BITS-1:0]   thr_reg;
    logic                    any_reg;
    logic [IDX_BITS-1:0]     last_reg;
    logic [CNT_BITS-1:0]     issue_reg;
    logic [IDX_BITS-1:0]     data_idx_reg;
    logic                    found_reg;
    logic [IDX_BITS-1:0]     sel_reg;
    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [OUT_IDX_BITS-1:0] out_idx_reg;

    logic                      in_acc;
    logic                      action;
    logic                      table_id;
    logic [IN_IDX_BITS-1:0]    entry_index;
    logic [IN_WEIGHT_BITS-1:0] entry_weight;
    logic [SPEED_BITS-1:0]     entry_min_speed;
    logic                      entry_present;
    logic [SPEED_BITS-1:0]     speed;
    logic [FRAC_BITS-1:0]      random_fraction;

    wres_wr_t              wr;
    wres_rd_t              rd;
    wres_rsp_t             rsp;
    logic [TOTAL_BITS-1:0] acc_add;
    logic [PROD_BITS-1:0]  product;
    logic                  last_data;
    logic                  out_free;

    assign action          = s_axis_tuser[0];
    assign table_id        = s_axis_tuser[1];
    assign entry_index     = s_axis_tdata[3:0];
    assign entry_weight    = s_axis_tdata[19:4];
    assign entry_min_speed = s_axis_tdata[35:20];
    assign entry_present   = s_axis_tdata[36];
    assign speed           = s_axis_tdata[52:37];
    assign random_fraction = s_axis_tdata[68:53];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        wr.en        = in_acc && !action && (int'(table_id) < TABLE_COUNT)
                       && (int'(entry_index) < ENTRIES_PER_TABLE);
        wr.addr      = slot_addr(table_id, IDX_BITS'(entry_index));
        wr.weight    = sat_weight(entry_weight);
        wr.min_speed = entry_min_speed;
        wr.present   = entry_present;

        rd.en   = ((state_reg == ST_SUM) || (state_reg == ST_SCAN))
                  && (int'(issue_reg) < ENTRIES_PER_TABLE);
        rd.addr = slot_addr(tbl_reg, IDX_BITS'(issue_reg));
    end

    wres_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .speed (speed_reg),
        .rsp   (rsp)
    );

    assign acc_add   = acc_reg + TOTAL_BITS'(rsp.weight);
    assign product   = PROD_BITS'(frac_reg) * PROD_BITS'(acc_reg);
    assign last_data = rsp.valid && (data_idx_reg == IDX_BITS'(ENTRIES_PER_TABLE - 1));
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tbl_reg       <= 1'b0;
            speed_reg     <= '0;
            frac_reg      <= '0;
            acc_reg       <= '0;
            thr_reg       <= '0;
            any_reg       <= 1'b0;
            last_reg      <= '0;
            issue_reg     <= '0;
            data_idx_reg  <= '0;
            found_reg     <= 1'b0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            if (rd.en)
            begin
                issue_reg <= issue_reg + CNT_BITS'(1);
            end
            if (rsp.valid)
            begin
                data_idx_reg <= data_idx_reg + IDX_BITS'(1);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && action)
                    begin
                        tbl_reg      <= table_id;
                        speed_reg    <= speed;
                        frac_reg     <= random_fraction;
                        acc_reg      <= '0;
                        any_reg      <= 1'b0;
                        last_reg     <= '0;
                        issue_reg    <= '0;
                        data_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        sel_reg      <= '0;
                        if (int'(table_id) < TABLE_COUNT)
                            state_reg <= ST_SUM;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_SUM:
                begin
                    if (rsp.valid && rsp.eligible)
                    begin
                        acc_reg  <= acc_add;
                        any_reg  <= 1'b1;
                        last_reg <= data_idx_reg;
                    end
                    if (last_data)
                    begin
                        if (rsp.eligible ? (acc_add != '0) : (any_reg && (acc_reg != '0)))
                            state_reg <= ST_MUL;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_MUL:
                begin
                    thr_reg      <= TOTAL_BITS'(product >> FRAC_BITS);
                    acc_reg      <= '0;
                    issue_reg    <= '0;
                    data_idx_reg <= '0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (rsp.valid && rsp.eligible)
                    begin
                        acc_reg <= acc_add;
                    end
                    if (rsp.valid && rsp.eligible && (acc_add >= thr_reg))
                    begin
                        found_reg <= 1'b1;
                        sel_reg   <= data_idx_reg;
                        state_reg <= ST_DONE;
                    end
                    else if (last_data)
                    begin
                        found_reg <= 1'b1;
                        sel_reg   <= last_reg;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_idx_reg   <= OUT_IDX_BITS'(sel_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_idx_reg);
    assign m_axis_tuser  = out_found_reg;

endmodule

// ===== rtl/wres_checker.sv =====
// Port-level checker of the weighted random entry selector, bound to the top level.
`include "weighted_random_entry_selector_top_defines.svh"

module wres_checker
    import wres_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    input logic [IN_USER_BITS-1:0]  s_axis_tuser,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                     m_axis_tuser
);

    `WRES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
    `WRES_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "no-match result carries a nonzero index")
    `WRES_ASSERT_NEXT(a_write_fast, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], s_axis_tready, "write word did not finish in one cycle")
    `WRES_ASSERT_NEXT(a_select_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready, "input taken while a select is in work")

endmodule

bind weighted_random_entry_selector_top wres_checker u_wres_checker (.*);
